FILE: rtl/core/cau_pkg.sv
// shared types and constants of the complex arithmetic unit
// no dependencies; imported by the channel interfaces and the top level

package cau_pkg;

	// default sizing
	localparam int DEF_DATA_WIDTH = 32;
	localparam int DEF_FRAC_BITS  = 16;
	localparam int DEF_MAX_EXP    = 31;
	localparam int OPCODE_W       = 3;
	localparam int EXP_W          = 6;

	// operation codes
	typedef enum logic [OPCODE_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_POW = 3'd4,
		OP_MAG = 3'd5
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SCALE,
		S_DIVCHK,
		S_DIV,
		S_DSAT,
		S_SQRT,
		S_DONE
	} state_t;

	// product job run by the shared multiplier
	typedef enum logic [1:0] {
		K_MUL,
		K_DIV,
		K_MAG
	} kind_t;

endpackage

FILE: rtl/core/cau_if.sv
// request and response channel interfaces of the complex arithmetic unit
// depends on cau_pkg

interface cau_req_if import cau_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic [OPCODE_W-1:0]          opcode;
	logic signed [DATA_WIDTH-1:0] a_re;
	logic signed [DATA_WIDTH-1:0] a_im;
	logic signed [DATA_WIDTH-1:0] b_re;
	logic signed [DATA_WIDTH-1:0] b_im;
	logic signed [EXP_W-1:0]      exponent;

	modport source (output valid, opcode, a_re, a_im, b_re, b_im, exponent, input ready);
	modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, exponent, output ready);
endinterface

interface cau_rsp_if import cau_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] res_re;
	logic signed [DATA_WIDTH-1:0] res_im;
	logic                         overflow_flag;
	logic                         div_zero_flag;

	modport source (output valid, res_re, res_im, overflow_flag, div_zero_flag, input ready);
	modport sink   (input valid, res_re, res_im, overflow_flag, div_zero_flag, output ready);
endinterface

FILE: rtl/core/complex_arithmetic_unit_top.sv
// complex arithmetic unit: add, sub, mul, div, integer power, magnitude in fixed point
// depends on cau_pkg and the channel interfaces in cau_if.sv
//
// channel | dir | payload                                         | handshake
// req     | in  | opcode, a_re, a_im, b_re, b_im, exponent        | valid / ready
// rsp     | out | res_re, res_im, overflow_flag, div_zero_flag    | valid / ready
//
// one item at a time; one shared signed multiplier plus a restoring divider and
// an integer square root sequencer do the work
// a zero divisor skips the divide steps, and a negative power exponent ends in a
// reciprocal division after any repeated multiplies; the divider makes one quotient
// bit per cycle, and every product goes through the single multiplier
// reset clears the sequencer, the response valid and the product valid only
// a held response does not stop the next item from being taken, but a finished item
// waits in the last state until the earlier response has gone

module complex_arithmetic_unit_top import cau_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH,
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	parameter int MAX_EXP    = DEF_MAX_EXP
) (
	input logic       clk,
	input logic       arst_n,
	cau_req_if.sink   req,
	cau_rsp_if.source rsp
);

	localparam int W   = DATA_WIDTH;
	localparam int QW  = 2 * W + FRAC_BITS;
	localparam int CW  = $clog2(QW);
	localparam int PCW = $clog2(MAX_EXP + 1);

	localparam logic [2:0] STEP_RR      = 3'd0;
	localparam logic [2:0] STEP_II      = 3'd1;
	localparam logic [2:0] STEP_RI      = 3'd2;
	localparam logic [2:0] STEP_IR      = 3'd3;
	localparam logic [2:0] STEP_YRR     = 3'd4;
	localparam logic [2:0] STEP_YII     = 3'd5;
	localparam logic [2:0] STEP_MUL_END = 3'd4;
	localparam logic [2:0] STEP_DIV_END = 3'd6;

	localparam logic [W-1:0]   MAXV     = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]   MINV     = {1'b1, {(W-1){1'b0}}};
	localparam logic [2*W:0]   LIM_WIDE = {{(W+2){1'b0}}, {(W-1){1'b1}}};
	localparam logic [W-1:0]   ONE_BIT  = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic           ONE_OVF  = (FRAC_BITS >= W - 1);
	localparam logic [W-1:0]   ONE_VAL  = ONE_OVF ? MAXV : ONE_BIT;
	localparam logic [2*W-1:0] SQ_TOP   = {2'b01, {(2*W-2){1'b0}}};

	// saturate a sign and magnitude pair, result is {overflow, value}
	function automatic logic [W:0] sat_mag(input logic neg, input logic [2*W:0] mag);
		logic [W:0] r;
		if (!neg) begin
			if (mag > LIM_WIDE) r = {1'b1, MAXV};
			else r = {1'b0, mag[W-1:0]};
		end else begin
			if (mag > LIM_WIDE + (2*W+1)'(1)) r = {1'b1, MINV};
			else r = {1'b0, ~mag[W-1:0] + W'(1)};
		end
		return r;
	endfunction

	// product sum scaled down by the fraction bits, toward zero, then saturated
	function automatic logic [W:0] scale_sat(input logic [2*W:0] v);
		logic           neg;
		logic [2*W:0]   mag;
		neg = v[2*W];
		mag = neg ? (~v + (2*W+1)'(1)) : v;
		return sat_mag(neg, mag >> FRAC_BITS);
	endfunction

	state_t state_q, state_d;
	op_t    op_q;
	kind_t  kind_q;

	logic signed [W-1:0] x_re_q, x_im_q, y_re_q, y_im_q;
	logic                e_neg_q;
	logic [PCW-1:0]      pw_cnt_q;
	logic [2:0]          step_q;
	logic                ovf_q, dz_q;
	logic [W-1:0]        res_re_q, res_im_q;

	logic signed [W-1:0]   ma, mb;
	logic signed [2*W-1:0] prod_s1;
	logic [2:0]            pidx_s1;
	logic                  pv_s1;

	logic [2*W:0]   acc_re_q, acc_im_q;
	logic [2*W-1:0] den_q;

	logic [2*W-1:0] num_re_q, num_im_q;
	logic [2*W:0]   rem_re_q, rem_im_q;
	logic [W:0]     q_re_q, q_im_q;
	logic           big_re_q, big_im_q, neg_re_q, neg_im_q;
	logic [CW-1:0]  div_cnt_q;

	logic [2*W-1:0] root_q, sbit_q;

	logic         ovalid_q;
	logic [W-1:0] out_re_q, out_im_q;
	logic         out_ovf_q, out_dz_q;

	// request decode
	logic           accept;
	op_t            op_in;
	logic [6:0]     ex_w, abs_e;
	logic [PCW-1:0] pw_n;
	logic [W:0]     sum_re, sum_im;
	logic [W:0]     as_re, as_im;

	assign accept = req.valid && req.ready;
	assign op_in  = op_t'(req.opcode);

	always_comb begin
		ex_w  = {req.exponent[EXP_W-1], req.exponent};
		abs_e = ex_w[6] ? (~ex_w + 7'd1) : ex_w;
		pw_n  = (int'(abs_e) > MAX_EXP) ? PCW'(MAX_EXP) : PCW'(abs_e);
	end

	// add and subtract path
	always_comb begin
		if (op_in == OP_SUB) begin
			sum_re = {req.a_re[W-1], req.a_re} - {req.b_re[W-1], req.b_re};
			sum_im = {req.a_im[W-1], req.a_im} - {req.b_im[W-1], req.b_im};
		end else begin
			sum_re = {req.a_re[W-1], req.a_re} + {req.b_re[W-1], req.b_re};
			sum_im = {req.a_im[W-1], req.a_im} + {req.b_im[W-1], req.b_im};
		end
		as_re = sat_mag(sum_re[W],
			{{W{1'b0}}, sum_re[W] ? (~sum_re + (W+1)'(1)) : sum_re});
		as_im = sat_mag(sum_im[W],
			{{W{1'b0}}, sum_im[W] ? (~sum_im + (W+1)'(1)) : sum_im});
	end

	// shared multiplier operand select
	always_comb begin
		case (step_q)
			STEP_RR: begin ma = x_re_q; mb = y_re_q; end
			STEP_II: begin ma = x_im_q; mb = y_im_q; end
			STEP_RI: begin ma = x_re_q; mb = y_im_q; end
			STEP_IR: begin ma = x_im_q; mb = y_re_q; end
			STEP_YRR: begin ma = y_re_q; mb = y_re_q; end
			STEP_YII: begin ma = y_im_q; mb = y_im_q; end
			default: begin ma = x_re_q; mb = y_re_q; end
		endcase
	end

	// sequencer decisions
	logic [2:0]     job_end;
	logic           pw_last;
	logic           div_done;
	logic           out_load;
	logic [W:0]     sc_re, sc_im, qs_re, qs_im, sq_res;
	logic [2*W:0]   r2_re, r2_im, rn_re, rn_im, sq_t;
	logic           ge_re, ge_im, sq_ge;

	assign job_end  = (kind_q == K_MUL) ? STEP_MUL_END : STEP_DIV_END;
	assign pw_last  = (pw_cnt_q == PCW'(1));
	assign div_done = (div_cnt_q == CW'(QW - 1));
	assign out_load = (state_q == S_DONE) && (!ovalid_q || rsp.ready);
	assign sc_re    = scale_sat(acc_re_q);
	assign sc_im    = scale_sat(acc_im_q);
	assign qs_re    = sat_mag(neg_re_q, big_re_q ? '1 : {{W{1'b0}}, q_re_q});
	assign qs_im    = sat_mag(neg_im_q, big_im_q ? '1 : {{W{1'b0}}, q_im_q});
	assign sq_res   = sat_mag(1'b0, {1'b0, root_q});

	// restoring divider lanes, one quotient bit per cycle
	always_comb begin
		r2_re = {rem_re_q[2*W-1:0], num_re_q[2*W-1]};
		r2_im = {rem_im_q[2*W-1:0], num_im_q[2*W-1]};
		ge_re = r2_re >= {1'b0, den_q};
		ge_im = r2_im >= {1'b0, den_q};
		rn_re = ge_re ? (r2_re - {1'b0, den_q}) : r2_re;
		rn_im = ge_im ? (r2_im - {1'b0, den_q}) : r2_im;
	end

	// square root step
	always_comb begin
		sq_t  = {1'b0, root_q} + {1'b0, sbit_q};
		sq_ge = {1'b0, den_q} >= sq_t;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_in)
						OP_MUL, OP_DIV, OP_MAG: state_d = S_MUL;
						OP_POW: begin
							if (req.exponent == '0) state_d = S_DONE;
							else if (pw_n == PCW'(1) && !req.exponent[EXP_W-1])
								state_d = S_DONE;
							else state_d = S_MUL;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_MUL: begin
				if (step_q == job_end) begin
					case (kind_q)
						K_DIV: state_d = S_DIVCHK;
						K_MAG: state_d = S_SQRT;
						default: state_d = S_SCALE;
					endcase
				end
			end
			S_SCALE: begin
				if (op_q == OP_POW && (!pw_last || e_neg_q)) state_d = S_MUL;
				else state_d = S_DONE;
			end
			S_DIVCHK: state_d = (den_q == '0) ? S_DONE : S_DIV;
			S_DIV: if (div_done) state_d = S_DSAT;
			S_DSAT: state_d = S_DONE;
			S_SQRT: if (sbit_q == '0) state_d = S_DONE;
			S_DONE: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// control flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			pv_s1    <= 1'b0;
		end else begin
			pv_s1 <= (state_q == S_MUL) && (step_q != job_end);
			if (out_load) ovalid_q <= 1'b1;
			else if (rsp.ready) ovalid_q <= 1'b0;
		end
	end

	// multiplier output stage
	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		pidx_s1 <= step_q;
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q     <= op_in;
					e_neg_q  <= req.exponent[EXP_W-1];
					ovf_q    <= 1'b0;
					dz_q     <= 1'b0;
					x_re_q   <= req.a_re;
					x_im_q   <= req.a_im;
					y_re_q   <= req.b_re;
					y_im_q   <= req.b_im;
					acc_re_q <= '0;
					acc_im_q <= '0;
					den_q    <= '0;
					pw_cnt_q <= pw_n - PCW'(1);
					step_q   <= STEP_RR;
					kind_q   <= K_MUL;
					res_re_q <= '0;
					res_im_q <= '0;
					case (op_in)
						OP_ADD, OP_SUB: begin
							res_re_q <= as_re[W-1:0];
							res_im_q <= as_im[W-1:0];
							ovf_q    <= as_re[W] | as_im[W];
						end
						OP_DIV: kind_q <= K_DIV;
						OP_MAG: begin
							kind_q <= K_MAG;
							step_q <= STEP_YRR;
							y_re_q <= req.a_re;
							y_im_q <= req.a_im;
						end
						OP_POW: begin
							ovf_q  <= ONE_OVF;
							y_re_q <= req.a_re;
							y_im_q <= req.a_im;
							if (req.exponent == '0) begin
								res_re_q <= ONE_VAL;
							end else if (pw_n == PCW'(1)) begin
								res_re_q <= req.a_re;
								res_im_q <= req.a_im;
								// a single power with a negative sign is 1 / a
								kind_q   <= K_DIV;
								x_re_q   <= ONE_VAL;
								x_im_q   <= '0;
							end
						end
						default: ;
					endcase
				end
			end
			S_MUL: begin
				if (step_q != job_end) step_q <= step_q + 3'd1;
				root_q <= '0;
				sbit_q <= SQ_TOP;
				// accumulate the registered product
				if (pv_s1) begin
					case (pidx_s1)
						STEP_RR: acc_re_q <= acc_re_q + {prod_s1[2*W-1], prod_s1};
						STEP_II: begin
							if (kind_q == K_MUL)
								acc_re_q <= acc_re_q - {prod_s1[2*W-1], prod_s1};
							else acc_re_q <= acc_re_q + {prod_s1[2*W-1], prod_s1};
						end
						STEP_RI: begin
							if (kind_q == K_MUL)
								acc_im_q <= acc_im_q + {prod_s1[2*W-1], prod_s1};
							else acc_im_q <= acc_im_q - {prod_s1[2*W-1], prod_s1};
						end
						STEP_IR: acc_im_q <= acc_im_q + {prod_s1[2*W-1], prod_s1};
						default: den_q <= den_q + $unsigned(prod_s1);
					endcase
				end
			end
			S_SCALE: begin
				x_re_q   <= sc_re[W-1:0];
				x_im_q   <= sc_im[W-1:0];
				res_re_q <= sc_re[W-1:0];
				res_im_q <= sc_im[W-1:0];
				ovf_q    <= ovf_q | sc_re[W] | sc_im[W];
				acc_re_q <= '0;
				acc_im_q <= '0;
				den_q    <= '0;
				step_q   <= STEP_RR;
				pw_cnt_q <= pw_cnt_q - PCW'(1);
				// last power with a negative sign: reciprocal follows
				if (op_q == OP_POW && pw_last && e_neg_q) begin
					kind_q <= K_DIV;
					x_re_q <= ONE_VAL;
					x_im_q <= '0;
					y_re_q <= sc_re[W-1:0];
					y_im_q <= sc_im[W-1:0];
				end
			end
			S_DIVCHK: begin
				if (den_q == '0) begin
					dz_q     <= 1'b1;
					res_re_q <= x_re_q[W-1] ? MINV : MAXV;
					res_im_q <= x_im_q[W-1] ? MINV : MAXV;
				end else begin
					neg_re_q  <= acc_re_q[2*W];
					neg_im_q  <= acc_im_q[2*W];
					num_re_q  <= acc_re_q[2*W] ? (~acc_re_q[2*W-1:0] + (2*W)'(1))
						: acc_re_q[2*W-1:0];
					num_im_q  <= acc_im_q[2*W] ? (~acc_im_q[2*W-1:0] + (2*W)'(1))
						: acc_im_q[2*W-1:0];
					rem_re_q  <= '0;
					rem_im_q  <= '0;
					q_re_q    <= '0;
					q_im_q    <= '0;
					big_re_q  <= 1'b0;
					big_im_q  <= 1'b0;
					div_cnt_q <= '0;
				end
			end
			S_DIV: begin
				num_re_q  <= num_re_q << 1;
				num_im_q  <= num_im_q << 1;
				rem_re_q  <= rn_re;
				rem_im_q  <= rn_im;
				big_re_q  <= big_re_q | q_re_q[W];
				big_im_q  <= big_im_q | q_im_q[W];
				q_re_q    <= {q_re_q[W-1:0], ge_re};
				q_im_q    <= {q_im_q[W-1:0], ge_im};
				div_cnt_q <= div_cnt_q + CW'(1);
			end
			S_DSAT: begin
				res_re_q <= qs_re[W-1:0];
				res_im_q <= qs_im[W-1:0];
				ovf_q    <= ovf_q | qs_re[W] | qs_im[W];
			end
			S_SQRT: begin
				if (sbit_q != '0) begin
					if (sq_ge) begin
						den_q  <= den_q - sq_t[2*W-1:0];
						root_q <= (root_q >> 1) + sbit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
				end else begin
					res_re_q <= sq_res[W-1:0];
					res_im_q <= '0;
					ovf_q    <= ovf_q | sq_res[W];
				end
			end
			default: ;
		endcase

		// response register
		if (out_load) begin
			out_re_q  <= res_re_q;
			out_im_q  <= res_im_q;
			out_ovf_q <= ovf_q;
			out_dz_q  <= dz_q;
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = ovalid_q;
	assign rsp.res_re        = out_re_q;
	assign rsp.res_im        = out_im_q;
	assign rsp.overflow_flag = out_ovf_q;
	assign rsp.div_zero_flag = out_dz_q;

	// magnitude never carries an imaginary part
	a_mag_im_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && op_q == OP_MAG) |-> (res_im_q == '0))
		else $error("magnitude result with nonzero imaginary part");

	// only division and negative powers can meet a zero divisor
	a_dz_source: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && dz_q) |-> (op_q == OP_DIV || op_q == OP_POW))
		else $error("zero divisor flag on an operation without division");

	// one item in flight: an accepted item closes the request side
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request side open while an item is in flight");

endmodule
